[rtl/b64ue_pkg.sv]
`default_nettype none

package b64ue_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [6:0] char_out;
		logic       run_end;
		logic       message_end;
	} out_item_t;

	// One output symbol: a base64 sextet or a "%3D" pad.
	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} sym_t;

	// Symbols caused by one input byte, in order from index 0.
	typedef struct packed {
		sym_t [3:0] sym;
		logic [1:0] last_idx;
		logic       fin;
	} sym_group_t;

	localparam logic [6:0] CH_PERCENT = 7'h25;
	localparam logic [6:0] CH_TWO     = 7'h32;
	localparam logic [6:0] CH_THREE   = 7'h33;
	localparam logic [6:0] CH_UPPER_B = 7'h42;
	localparam logic [6:0] CH_UPPER_D = 7'h44;
	localparam logic [6:0] CH_UPPER_F = 7'h46;
	localparam logic [6:0] CH_PLUS    = 7'h2b;
	localparam logic [6:0] CH_SLASH   = 7'h2f;
	localparam logic [6:0] CH_EQUAL   = 7'h3d;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_ZERO    = 7'h30;

	localparam logic [5:0] SEXTET_PLUS = 6'd62;

	function automatic logic [6:0] b64_char(input logic [5:0] s);
		logic [6:0] c;
		if (s < 6'd26) begin
			c = CH_UPPER_A + {1'b0, s};
		end else if (s < 6'd52) begin
			c = CH_LOWER_A + {1'b0, s} - 7'd26;
		end else if (s < SEXTET_PLUS) begin
			c = CH_ZERO + {1'b0, s} - 7'd52;
		end else if (s == SEXTET_PLUS) begin
			c = CH_PLUS;
		end else begin
			c = CH_SLASH;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/b64ue_pack.sv]
`default_nettype none

module b64ue_pack (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire b64ue_pkg::in_item_t  item,
	output b64ue_pkg::sym_group_t     group
);
	import b64ue_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [7:0] b;

	assign b = item.data_byte;

	always_comb begin
		group = '0;
		group.fin = item.final_byte;
		case (phase_q)
			2'd1: begin
				group.sym[0] = '{pad: 1'b0, sextet: {carry_q[1:0], b[7:4]}};
				group.sym[1] = '{pad: 1'b0, sextet: {b[3:0], 2'b00}};
				group.sym[2] = '{pad: 1'b1, sextet: 6'd0};
				group.last_idx = item.final_byte ? 2'd2 : 2'd0;
				phase_d = 2'd2;
				carry_d = b[3:0];
			end
			2'd2: begin
				group.sym[0] = '{pad: 1'b0, sextet: {carry_q, b[7:6]}};
				group.sym[1] = '{pad: 1'b0, sextet: b[5:0]};
				group.last_idx = 2'd1;
				phase_d = 2'd0;
				carry_d = 4'd0;
			end
			default: begin
				group.sym[0] = '{pad: 1'b0, sextet: b[7:2]};
				group.sym[1] = '{pad: 1'b0, sextet: {b[1:0], 4'b0000}};
				group.sym[2] = '{pad: 1'b1, sextet: 6'd0};
				group.sym[3] = '{pad: 1'b1, sextet: 6'd0};
				group.last_idx = item.final_byte ? 2'd3 : 2'd0;
				phase_d = 2'd1;
				carry_d = {2'b00, b[1:0]};
			end
		endcase
		if (item.final_byte) begin
			phase_d = 2'd0;
			carry_d = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			carry_q <= 4'd0;
		end else if (take) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

`default_nettype wire

[rtl/b64ue_emit.sv]
`default_nettype none

module b64ue_emit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire b64ue_pkg::sym_group_t  group,
	output logic                        busy,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output b64ue_pkg::out_item_t        out_data
);
	import b64ue_pkg::*;

	sym_group_t grp_q;
	logic       grp_v_q;
	logic [1:0] idx_q;
	logic [1:0] sub_q;
	out_item_t  out_q;
	logic       out_v_q;

	sym_t       cur;
	logic       esc;
	logic       sym_done;
	logic       grp_done;
	logic       adv;
	logic [6:0] ch;

	assign cur      = grp_q.sym[idx_q];
	assign esc      = cur.pad | (&cur.sextet[5:1]);
	assign sym_done = !esc || (sub_q == 2'd2);
	assign grp_done = sym_done && (idx_q == grp_q.last_idx);
	assign adv      = grp_v_q && (!out_v_q || !out_stall);
	assign busy     = grp_v_q && !(adv && grp_done);

	always_comb begin
		case (sub_q)
			2'd0: ch = esc ? CH_PERCENT : b64_char(cur.sextet);
			2'd1: ch = cur.pad ? CH_THREE : CH_TWO;
			2'd2: ch = cur.pad ? CH_UPPER_D : (cur.sextet[0] ? CH_UPPER_F : CH_UPPER_B);
			default: ch = CH_PERCENT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_v_q <= 1'b0;
			grp_q   <= '0;
			idx_q   <= 2'd0;
			sub_q   <= 2'd0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
				out_q   <= '{char_out: ch, run_end: grp_done,
					message_end: grp_done && grp_q.fin};
				if (grp_done) begin
					idx_q   <= 2'd0;
					sub_q   <= 2'd0;
				end else if (sym_done) begin
					idx_q <= idx_q + 2'd1;
					sub_q <= 2'd0;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				grp_v_q <= 1'b1;
				grp_q   <= group;
			end else if (adv && grp_done) begin
				grp_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[rtl/base64_url_escaped_encoder.sv]
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | in_data  (data_byte, final_byte)
// out     | out | out_valid / out_stall| out_data (char_out, run_end, message_end)
//
// One character leaves per cycle while the output is not stalled; a byte causes
// 1 to 10 characters, sent by the character serializer after the symbol register.
// The next byte is taken as the predecessor's last character is registered.
// Reset clears the group phase, the carry bits and all valid flags.
// A stalled output holds its character; the serializer waits behind it.
`default_nettype none

module base64_url_escaped_encoder (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire b64ue_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output b64ue_pkg::out_item_t      out_data
);
	import b64ue_pkg::*;

	sym_group_t group;
	logic       busy;
	logic       take;

	assign take     = in_valid && !busy;
	assign in_stall = busy;

	b64ue_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_data),
		.group  (group)
	);

	b64ue_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.group     (group),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_msg_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_end |-> out_data.run_end)
		else $error("message end without run end");

	a_no_raw_escape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.char_out != CH_PLUS) && (out_data.char_out != CH_SLASH)
			&& (out_data.char_out != CH_EQUAL))
		else $error("unescaped character on output");

	a_accept_gives_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted byte produced no character");
`endif

endmodule

`default_nettype wire

[bench/b64ue_char_checker.sv]
`timescale 1ns / 100ps

module b64ue_char_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire b64ue_pkg::in_item_t  in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire b64ue_pkg::out_item_t out_data,
	output int                        fail_count,
	output int                        chars_pending
);
	import b64ue_pkg::*;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	out_item_t  expected_chars[$];
	logic [1:0] grp_phase;
	logic [3:0] carry;
	logic [6:0] byte_chars[0:11];
	int         n_chars;

	function automatic logic [6:0] sextet_ascii(input logic [5:0] s);
		int pos;
		pos = 8 * (63 - int'(s));
		return ALPHABET[pos +: 7];
	endfunction

	task automatic add_char(input logic [6:0] c);
		byte_chars[n_chars] = c;
		n_chars++;
	endtask

	task automatic add_sextet(input logic [5:0] s);
		logic [6:0] c;
		c = sextet_ascii(s);
		if (c == CH_PLUS) begin
			add_char(CH_PERCENT);
			add_char(CH_TWO);
			add_char(CH_UPPER_B);
		end else if (c == CH_SLASH) begin
			add_char(CH_PERCENT);
			add_char(CH_TWO);
			add_char(CH_UPPER_F);
		end else begin
			add_char(c);
		end
	endtask

	task automatic add_pad();
		add_char(CH_PERCENT);
		add_char(CH_THREE);
		add_char(CH_UPPER_D);
	endtask

	task automatic predict_byte(input in_item_t item);
		out_item_t e;
		n_chars = 0;
		case (grp_phase)
			PHASE_SECOND: begin
				add_sextet({carry[1:0], item.data_byte[7:4]});
				carry = item.data_byte[3:0];
				grp_phase = PHASE_THIRD;
				if (item.final_byte) begin
					add_sextet({carry, 2'b00});
					add_pad();
				end
			end
			PHASE_THIRD: begin
				add_sextet({carry, item.data_byte[7:6]});
				add_sextet(item.data_byte[5:0]);
				carry = '0;
				grp_phase = PHASE_FIRST;
			end
			default: begin
				add_sextet(item.data_byte[7:2]);
				carry = {2'b00, item.data_byte[1:0]};
				grp_phase = PHASE_SECOND;
				if (item.final_byte) begin
					add_sextet({carry[1:0], 4'b0000});
					add_pad();
					add_pad();
				end
			end
		endcase
		if (item.final_byte) begin
			grp_phase = PHASE_FIRST;
			carry = '0;
		end
		for (int i = 0; i < n_chars; i++) begin
			e.char_out    = byte_chars[i];
			e.run_end     = (i == n_chars - 1);
			e.message_end = item.final_byte && (i == n_chars - 1);
			expected_chars.push_back(e);
		end
	endtask

	task automatic check_char(input out_item_t got);
		out_item_t want;
		if (expected_chars.size() == 0) begin
			$error("out_data: no character expected, got %h", got);
			fail_count++;
		end else begin
			want = expected_chars.pop_front();
			if (got.char_out !== want.char_out) begin
				$error("char_out: expected %h, got %h", want.char_out, got.char_out);
				fail_count++;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end: expected %b, got %b", want.run_end, got.run_end);
				fail_count++;
			end
			if (got.message_end !== want.message_end) begin
				$error("message_end: expected %b, got %b", want.message_end,
					got.message_end);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			grp_phase = PHASE_FIRST;
			carry = '0;
			chars_pending = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(in_data);
			end
			if (out_valid && !out_stall) begin
				check_char(out_data);
			end
			chars_pending = expected_chars.size();
		end
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import b64ue_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 210;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	int        fail_count;
	int        chars_pending;
	int        cycles;
	bit        send_idle_on;
	bit        recv_stall_on;

	base64_url_escaped_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	b64ue_char_checker char_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// receiver backpressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_stall_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (send_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.data_byte <= b;
		in_data.final_byte <= fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = 8'hf8 | 8'($urandom_range(0, 7));
			1: b = {2'($urandom_range(0, 3)), 6'h3e | 6'($urandom_range(0, 1))};
			2: b = {4'($urandom_range(0, 15)), 4'hf};
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	initial begin
		int sent;
		int msg_len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_on = 1'b1;
		recv_stall_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'hfb, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'hf8, 1'b0);
		send_byte(8'hfe, 1'b0);
		send_byte(8'h3f, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'hfc, 1'b1);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			send_idle_on = !(sent >= 90 && sent < 115) && sent < 170;
			recv_stall_on = !(sent >= 60 && sent < 80) && sent < 170;
			msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			for (int i = 0; i < msg_len; i++) begin
				send_byte(pick_byte(), i == msg_len - 1);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (chars_pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0 && chars_pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
